/* hdl/plid_pkg.sv */
`default_nettype none
package plid_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int MODE_W   = 2;
  localparam int POS_W    = 11;
  localparam int CNT_W    = 11;
  localparam int LEN_W    = 11;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GET    = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic idle;
    logic check;
    logic rd_ptr_sel;
    logic init_ptr;
    logic step_ptr;
    logic move_issue;
    logic write_value;
    logic commit;
  } plid_cmd_t;

  typedef struct packed {
    logic accept;
    logic ok;
    logic is_insert;
    logic has_tail;
    logic last_move;
    logic out_free;
  } plid_sts_t;

endpackage
`default_nettype wire

/* hdl/plid_in_if.sv */
`default_nettype none
interface plid_in_if;
  import plid_pkg::*;

  logic                     valid;
  logic                     ready;
  logic        [MODE_W-1:0] mode;
  logic        [POS_W-1:0]  position;
  logic        [CNT_W-1:0]  count;
  logic signed [VAL_W-1:0]  value;

  modport source (output valid, mode, position, count, value, input ready);
  modport sink   (input valid, mode, position, count, value, output ready);
endinterface
`default_nettype wire

/* hdl/plid_out_if.sv */
`default_nettype none
interface plid_out_if;
  import plid_pkg::*;

  logic                     valid;
  logic                     ready;
  logic        [STAT_W-1:0] status;
  logic        [LEN_W-1:0]  length;
  logic signed [VAL_W-1:0]  data;

  modport source (output valid, status, length, data, input ready);
  modport sink   (input valid, status, length, data, output ready);
endinterface
`default_nettype wire

/* hdl/plid_datapath.sv */
`default_nettype none
module plid_datapath (
  input  wire                 clk,
  input  wire                 rst,
  plid_in_if.sink             in_ch,
  plid_out_if.source          out_ch,
  input  plid_pkg::plid_cmd_t cmd,
  output plid_pkg::plid_sts_t sts
);
  import plid_pkg::*;

  localparam logic [LEN_W:0] CAP_X = (LEN_W + 1)'(CAPACITY);

  logic        [VAL_W-1:0]  mem [CAPACITY];

  logic        [MODE_W-1:0] mode_q;
  logic        [POS_W-1:0]  pos_q;
  logic        [CNT_W-1:0]  cnt_q;
  logic        [VAL_W-1:0]  val_q;
  logic        [LEN_W-1:0]  len;
  logic        [LEN_W-1:0]  len_next;
  logic        [STAT_W-1:0] status_q;
  logic        [STAT_W-1:0] status_next;
  logic        [ADDR_W-1:0] ptr;
  logic                     move_pending;
  logic        [ADDR_W-1:0] move_addr;
  logic        [VAL_W-1:0]  rdata;
  logic        [ADDR_W-1:0] rd_addr;
  logic        [ADDR_W-1:0] pos_addr;

  logic                     out_valid;
  logic        [STAT_W-1:0] out_status;
  logic        [LEN_W-1:0]  out_length;
  logic        [VAL_W-1:0]  out_data;

  logic        [LEN_W:0]    pos_x;
  logic        [LEN_W:0]    len_x;
  logic        [LEN_W:0]    end_x;
  logic                     ins_bad;
  logic                     del_bad;
  logic                     get_bad;
  logic                     is_ins;

  assign pos_x    = (LEN_W + 1)'(pos_q);
  assign len_x    = (LEN_W + 1)'(len);
  assign end_x    = pos_x - 1'b1 + (LEN_W + 1)'(cnt_q);
  assign pos_addr = ADDR_W'(pos_q - 1'b1);
  assign is_ins   = (mode_q == MODE_INSERT);

  assign ins_bad = (pos_q == '0) || (pos_x > len_x + 1'b1);
  assign del_bad = (cnt_q == '0) || (pos_q == '0) || (pos_x > len_x) || (end_x > len_x);
  assign get_bad = (pos_q == '0) || (pos_x > len_x);

  always_comb begin
    unique case (mode_q)
      MODE_INSERT: status_next = ins_bad ? ST_RANGE : ((len_x >= CAP_X) ? ST_FULL : ST_DONE);
      MODE_DELETE: status_next = del_bad ? ST_RANGE : ST_DONE;
      MODE_GET:    status_next = get_bad ? ST_RANGE : ST_DONE;
      default:     status_next = ST_RANGE;
    endcase
  end

  always_comb begin
    len_next = len;
    if (status_q == ST_DONE) begin
      if (mode_q == MODE_INSERT) begin
        len_next = len + 1'b1;
      end else if (mode_q == MODE_DELETE) begin
        len_next = len - LEN_W'(cnt_q);
      end
    end
  end

  assign sts.accept    = in_ch.valid && in_ch.ready;
  assign sts.ok        = (status_next == ST_DONE);
  assign sts.is_insert = is_ins;
  assign sts.has_tail  = is_ins ? (pos_x <= len_x) :
                         ((mode_q == MODE_DELETE) && (end_x < len_x));
  assign sts.last_move = is_ins ? (ptr == pos_addr) : (ptr == ADDR_W'(len - 1'b1));
  assign sts.out_free  = !out_valid || out_ch.ready;

  assign rd_addr = cmd.rd_ptr_sel ? ptr : pos_addr;

  always_ff @(posedge clk) begin
    if (sts.accept) begin
      mode_q <= in_ch.mode;
      pos_q  <= in_ch.position;
      cnt_q  <= in_ch.count;
      val_q  <= in_ch.value;
    end
    if (cmd.check) begin
      status_q <= status_next;
    end
    if (cmd.init_ptr) begin
      ptr <= is_ins ? ADDR_W'(len - 1'b1) : ADDR_W'(end_x);
    end else if (cmd.step_ptr) begin
      ptr <= is_ins ? ptr - 1'b1 : ptr + 1'b1;
    end
    move_addr <= is_ins ? ptr + 1'b1 : ptr - ADDR_W'(cnt_q);
    rdata     <= mem[rd_addr];
    if (move_pending) begin
      mem[move_addr] <= rdata;
    end else if (cmd.write_value) begin
      mem[pos_addr] <= val_q;
    end
    if (cmd.commit) begin
      out_status <= status_q;
      out_length <= len_next;
      out_data   <= (mode_q == MODE_GET && status_q == ST_DONE) ? rdata : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len          <= '0;
      move_pending <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      move_pending <= cmd.move_issue;
      if (cmd.commit) begin
        len       <= len_next;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_ch.ready   = cmd.idle;
  assign out_ch.valid  = out_valid;
  assign out_ch.status = out_status;
  assign out_ch.length = out_length;
  assign out_ch.data   = out_data;

endmodule
`default_nettype wire

/* hdl/plid_ctrl.sv */
`default_nettype none
module plid_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  plid_pkg::plid_sts_t sts,
  output plid_pkg::plid_cmd_t cmd
);
  import plid_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CHECK  = 7'b0000010,
    S_SHIFT  = 7'b0000100,
    S_DRAIN  = 7'b0001000,
    S_WRITE  = 7'b0010000,
    S_FINISH = 7'b0100000,
    S_SETTLE = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (sts.accept) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check    = 1'b1;
        cmd.init_ptr = 1'b1;
        if (!sts.ok) begin
          state_next = S_FINISH;
        end else if (sts.has_tail) begin
          state_next = S_SHIFT;
        end else if (sts.is_insert) begin
          state_next = S_WRITE;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SHIFT: begin
        cmd.rd_ptr_sel = 1'b1;
        cmd.move_issue = 1'b1;
        cmd.step_ptr   = 1'b1;
        if (sts.last_move) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = sts.is_insert ? S_WRITE : S_FINISH;
      end
      S_WRITE: begin
        cmd.write_value = 1'b1;
        state_next      = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_SETTLE;
        end
      end
      S_SETTLE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* hdl/positional_list_insert_delete_core.sv */
// channel | dir | payload                        | handshake
// in_ch   | in  | mode, position, count, value   | valid/ready
// out_ch  | out | status, length, data           | valid/ready
//
// One transaction at a time. Get, rejected items and deletes with no tail go
// from check straight to commit, an append via the value write. Insert at p
// moves len-p+1 tail entries and delete of c at p moves len-p-c+1, one per cycle
// through the registered-read list memory, then drain, the value write (insert)
// and commit. Input reopens after a settle state. Synchronous reset empties the
// list; stored values are not cleared. A stalled result register holds commit.
`default_nettype none
module positional_list_insert_delete_core (
  input  wire        clk,
  input  wire        rst,
  plid_in_if.sink    in_ch,
  plid_out_if.source out_ch
);
  import plid_pkg::*;

  plid_cmd_t cmd;
  plid_sts_t sts;

  plid_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  plid_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    sts.accept |=> !in_ch.ready)
    else $error("transaction accepted while another is in progress");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> ((LEN_W + 1)'(out_ch.length) <= (LEN_W + 1)'(CAPACITY)))
    else $error("length beyond capacity");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status != ST_DONE) |-> (out_ch.data == '0))
    else $error("nonzero data on rejected transaction");

  a_no_commit_while_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.idle |-> !cmd.commit && !cmd.move_issue && !cmd.write_value)
    else $error("datapath command while idle");

endmodule
`default_nettype wire

/* bench/plid_checker.sv */
module plid_checker
  import plid_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  plid_in_if   in_mon,
  plid_out_if  out_mon,
  output int   fail_count,
  output int   list_len,
  output int   awaiting,
  output int   results_seen,
  output int   full_rejects,
  output int   peak_len
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  length;
    logic [VAL_W-1:0]  data;
  } plid_result_t;

  plid_result_t     result_q[$];
  plid_result_t     got;
  plid_result_t     want;
  logic [VAL_W-1:0] shadow_list [CAPACITY];

  function automatic plid_result_t apply_op(input logic [MODE_W-1:0] op,
                                            input logic [POS_W-1:0]  pos,
                                            input logic [CNT_W-1:0]  cnt,
                                            input logic [VAL_W-1:0]  val);
    plid_result_t r;
    int p;
    int c;
    int k;
    p = pos;
    c = cnt;
    r.status = ST_RANGE;
    r.data   = '0;
    case (op)
      MODE_INSERT: begin
        if (p != 0 && p <= list_len + 1) begin
          if (list_len >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (k = list_len; k >= p; k--) shadow_list[k] = shadow_list[k-1];
            shadow_list[p-1] = val;
            list_len++;
            r.status = ST_DONE;
          end
        end
      end
      MODE_DELETE: begin
        if (c != 0 && p != 0 && p <= list_len && p - 1 + c <= list_len) begin
          for (k = p - 1; k + c < list_len; k++) shadow_list[k] = shadow_list[k+c];
          list_len -= c;
          r.status = ST_DONE;
        end
      end
      MODE_GET: begin
        if (p != 0 && p <= list_len) begin
          r.status = ST_DONE;
          r.data   = shadow_list[p-1];
        end
      end
      default: ;
    endcase
    r.length = LEN_W'(list_len);
    return r;
  endfunction

  task automatic log_mismatch(input string what, input plid_result_t exp_r,
                              input plid_result_t act_r);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t mismatch (%s): expected status %0d length %0d data %0d, got status %0d length %0d data %0d",
               $realtime, what, exp_r.status, exp_r.length, $signed(exp_r.data),
               act_r.status, act_r.length, $signed(act_r.data));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      list_len   = 0;
      fail_count = 0;
      result_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.status, out_mon.length, out_mon.data};
        results_seen++;
        if (result_q.size() == 0) begin
          log_mismatch("result with no transaction pending", '0, got);
        end else begin
          want = result_q.pop_front();
          if (got.status !== want.status || got.length !== want.length ||
              got.data !== want.data)
            log_mismatch("result fields", want, got);
          if (want.status == ST_FULL) full_rejects++;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        result_q.push_back(apply_op(in_mon.mode, in_mon.position, in_mon.count,
                                    in_mon.value));
        if (list_len > peak_len) peak_len = list_len;
      end
    end
    awaiting = result_q.size();
  end

endmodule

/* bench/positional_list_insert_delete_core_tb.sv */
module positional_list_insert_delete_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import plid_pkg::*;

  localparam int RANDOM_ITEMS = 550;
  localparam int HOLD_CYCLES  = 300;

  logic clk;
  logic rst;
  logic quiet;
  logic hold_long;
  int   fail_count;
  int   list_len;
  int   awaiting;
  int   results_seen;
  int   full_rejects;
  int   peak_len;
  int   sent;
  int   run_left;
  int   run_pos;

  plid_in_if  in_bus();
  plid_out_if out_bus();

  positional_list_insert_delete_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  plid_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .fail_count   (fail_count),
    .list_len     (list_len),
    .awaiting     (awaiting),
    .results_seen (results_seen),
    .full_rejects (full_rejects),
    .peak_len     (peak_len)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("positional_list_insert_delete_core_tb: done, errors");
    $finish;
  end

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '1;
      3:       return '0;
      default: return $urandom();
    endcase
  endfunction

  task automatic push_item(input logic [MODE_W-1:0] op, input int pos, input int cnt,
                           input logic [VAL_W-1:0] val);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.mode     <= op;
    in_bus.position <= POS_W'(pos);
    in_bus.count    <= CNT_W'(cnt);
    in_bus.value    <= val;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic random_item();
    int held;
    int kind;
    int pos;
    int cnt;
    int lim;
    held = list_len;
    if (run_left > 0) begin
      push_item(MODE_INSERT, run_pos, run_left, pick_value());
      run_pos++;
      run_left--;
      return;
    end
    kind = $urandom_range(0, 99);
    if (held == 0 && kind < 80) kind = 0;
    if (held >= 96 && kind < 38) kind = 40;
    if (kind < 38) begin
      pos = $urandom_range(1, held + 1);
      cnt = 1;
      if ($urandom_range(0, 3) == 0) begin
        run_left = $urandom_range(1, 7);
        run_pos  = pos + 1;
        cnt      = run_left + 1;
      end
      push_item(MODE_INSERT, pos, cnt, pick_value());
    end else if (kind < 58) begin
      pos = $urandom_range(1, held);
      lim = held - pos + 1;
      cnt = ($urandom_range(0, 5) == 0) ? lim : $urandom_range(1, (lim < 6) ? lim : 6);
      push_item(MODE_DELETE, pos, cnt, $urandom());
    end else if (kind < 80) begin
      push_item(MODE_GET, $urandom_range(1, held), $urandom_range(0, 2047), $urandom());
    end else if (kind < 90) begin
      case ($urandom_range(0, 5))
        0:       push_item(MODE_INSERT, held + 2, 1, pick_value());
        1:       push_item(MODE_DELETE, held + 1, 1, $urandom());
        2:       push_item(MODE_GET, held + 1, 1, $urandom());
        3:       push_item(MODE_DELETE, 1, held + 1, $urandom());
        4:       push_item(MODE_DELETE, 1, 0, $urandom());
        default: push_item(MODE_GET, 0, 1, $urandom());
      endcase
    end else begin
      push_item(MODE_W'($urandom_range(0, 3)),
                $urandom_range(0, 2047), $urandom_range(0, 2047), $urandom());
    end
  endtask

  // result side: random stalls, one long hold-off to back the block up
  initial begin
    int  stall;
    bit  long_done;
    long_done = 1'b0;
    out_bus.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_long && !long_done) begin
        long_done = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 13);
        if (stall > 0) begin
          out_bus.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      @(negedge clk);
    end
  end

  initial begin
    int i;
    rst             = 1'b1;
    quiet           = 1'b0;
    hold_long       = 1'b0;
    sent            = 0;
    run_left        = 0;
    run_pos         = 0;
    in_bus.valid    = 1'b0;
    in_bus.mode     = MODE_INSERT;
    in_bus.position = '0;
    in_bus.count    = '0;
    in_bus.value    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty list, bad positions, three-value run, front/middle/end inserts, gets, deletes
    push_item(MODE_GET, 1, 1, '0);
    push_item(MODE_DELETE, 1, 1, '0);
    push_item(MODE_INSERT, 0, 1, 32'h1234_5678);
    push_item(MODE_INSERT, 2, 1, 32'h1234_5678);
    push_item(MODE_INSERT, 1, 3, 32'h7fff_ffff);
    push_item(MODE_INSERT, 2, 2, 32'h8000_0000);
    push_item(MODE_INSERT, 3, 1, '1);
    push_item(MODE_INSERT, 1, 1, '0);
    push_item(MODE_INSERT, 3, 1, 32'h5555_5555);
    push_item(MODE_INSERT, 6, 1, 32'haaaa_aaaa);
    push_item(MODE_GET, 1, 1, '0);
    push_item(MODE_GET, 6, 1, '0);
    push_item(MODE_GET, 7, 1, '0);
    push_item(MODE_GET, 0, 1, '0);
    push_item(MODE_W'(3), 1, 1, '1);
    push_item(MODE_DELETE, 1, 0, '0);
    push_item(MODE_DELETE, 5, 3, '0);
    push_item(MODE_DELETE, 7, 1, '0);
    push_item(MODE_DELETE, 2, 2, '0);
    push_item(MODE_GET, 2, 1, '0);
    push_item(MODE_INSERT, 2047, 2047, '1);
    push_item(MODE_DELETE, 1, 2047, '0);
    push_item(MODE_DELETE, 1, list_len, '0);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i == 200) hold_long = 1'b1;
      random_item();
    end
    quiet = 1'b0;
    while (list_len > 0) push_item(MODE_DELETE, 1, list_len, '0);
    push_item(MODE_GET, 1, 1, '0);
    in_bus.valid <= 1'b0;

    while (awaiting != 0) @(negedge clk);
    repeat (64) @(negedge clk);

    $display("%0d transactions sent, %0d results checked, %0d full-store rejects",
             sent, results_seen, full_rejects);
    $display("list length peaked at %0d of %0d entries", peak_len, CAPACITY);
    if (fail_count == 0 && awaiting == 0) begin
      $display("positional_list_insert_delete_core_tb: done, clean");
    end else begin
      $display("positional_list_insert_delete_core_tb: done, errors");
    end
    $finish;
  end

endmodule
